// ===== rtl/clse_pkg.sv =====
package clse_pkg;

	localparam int Capacity  = 16;
	localparam int DataWidth = 32;
	localparam int IdxW      = $clog2(Capacity);
	localparam int CntW      = $clog2(Capacity + 1);

	typedef enum logic [2:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_INS_POS  = 3'd2,
		OP_REMOVE   = 3'd3,
		OP_SEARCH   = 3'd4,
		OP_GET      = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
		logic [4:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [3:0]         found_position;
		logic [1:0]         status;
		logic [4:0]         count;
		logic               is_empty;
	} rsp_t;

endpackage

// ===== rtl/clse_free_find.sv =====
// Lowest free pool slot, priority encoder over the in-use vector.
module clse_free_find (
	input  logic [clse_pkg::Capacity-1:0] in_use,
	output logic [clse_pkg::IdxW-1:0]     slot
);
	import clse_pkg::*;

	always_comb begin
		slot = '0;
		for (int i = Capacity - 1; i >= 0; i--) begin
			if (!in_use[i]) begin
				slot = IdxW'(i);
			end
		end
	end
endmodule

// ===== rtl/circular_list_sequence_engine_core.sv =====
// Channel   | Ports                    | Handshake
// ----------+--------------------------+-------------------------------------
// request   | start, busy, req         | taken when start && !busy
// result    | done, rsp                | one cycle wide on done, no stall
//
// Sequence: insert, remove and get walk k links with the shared link walker
// (one node per cycle), then apply and done; search walks and goes straight
// to done (k up to count when nothing matches); a rejected request goes
// straight to done. done rises on the edge that clears busy.
// Reset clears the in-use bits, head and count at once; the node memory
// keeps no reset and is only read on live nodes.
// busy stays high from the accepting edge until the done cycle.
module circular_list_sequence_engine_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  clse_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output clse_pkg::rsp_t  rsp
);
	import clse_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_APPLY, S_DONE} state_t;

	// node pool: value and both links
	logic signed [DataWidth-1:0] val_q  [Capacity];
	logic [IdxW-1:0]             next_q [Capacity];
	logic [IdxW-1:0]             prev_q [Capacity];
	logic [Capacity-1:0]         used_q;
	logic [IdxW-1:0]             head_q;
	logic [CntW-1:0]             cnt_q;

	state_t                      state_q;
	op_t                         op_q;
	logic signed [DataWidth-1:0] v_q;
	logic [CntW-1:0]             pos_q;   // target position
	logic [CntW-1:0]             step_q;  // links walked so far
	logic [IdxW-1:0]             node_q;  // walker
	logic [IdxW-1:0]             free_slot;

	clse_free_find u_free (.in_use(used_q), .slot(free_slot));

	logic [CntW-1:0] in_pos;
	op_t             in_op;
	status_t         pre_st;
	logic            pre_ok;

	// Request decode: range and capacity checks before any walking.
	always_comb begin
		in_op  = op_t'(req.op);
		in_pos = req.position;
		pre_st = ST_OK;
		unique case (in_op)
			OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
				if (in_op == OP_INS_HEAD) in_pos = '0;
				if (in_op == OP_INS_TAIL) in_pos = cnt_q;
				if (in_pos > cnt_q) pre_st = ST_RANGE;
				else if (cnt_q >= CntW'(Capacity)) pre_st = ST_FULL;
			end
			OP_REMOVE, OP_GET: if (in_pos >= cnt_q) pre_st = ST_RANGE;
			OP_SEARCH: if (cnt_q == '0) pre_st = ST_RANGE;
			default: pre_st = ST_RANGE;
		endcase
		pre_ok = (pre_st == ST_OK);
	end

	// Insert at count walks to head (position wraps to head, as a tail insert).
	logic [CntW-1:0] walk_len;
	assign walk_len = (pos_q >= cnt_q) ? '0 : pos_q;

	logic [IdxW-1:0] bef, nx, pv;
	assign bef = prev_q[node_q];
	assign nx  = next_q[node_q];
	assign pv  = prev_q[node_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			head_q  <= '0;
			cnt_q   <= '0;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						busy   <= 1'b1;
						op_q   <= in_op;
						v_q    <= req.value;
						pos_q  <= in_pos;
						step_q <= '0;
						node_q <= head_q;
						rsp    <= '{result_value: '0, found_position: '0, status: pre_st,
							count: '0, is_empty: 1'b0};
						state_q <= pre_ok ? S_WALK : S_DONE;
					end
				end
				S_WALK: begin
					if (op_q == OP_SEARCH) begin
						if (step_q >= cnt_q) begin
							rsp.status <= ST_NOTFOUND;
							state_q    <= S_DONE;
						end else if (val_q[node_q] == v_q) begin
							rsp.found_position <= step_q[IdxW-1:0];
							state_q            <= S_DONE;
						end else begin
							node_q <= next_q[node_q];
							step_q <= step_q + 1'b1;
						end
					end else if (step_q < walk_len) begin
						node_q <= next_q[node_q];
						step_q <= step_q + 1'b1;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					unique case (op_q)
						OP_GET: rsp.result_value <= val_q[node_q];
						OP_REMOVE: begin
							rsp.result_value <= val_q[node_q];
							used_q[node_q]   <= 1'b0;
							cnt_q            <= cnt_q - 1'b1;
							if (cnt_q == CntW'(1)) head_q <= '0;
							else begin
								next_q[pv] <= nx;
								prev_q[nx] <= pv;
								if (node_q == head_q) head_q <= nx;
							end
						end
						default: begin
							used_q[free_slot] <= 1'b1;
							val_q[free_slot]  <= v_q;
							cnt_q             <= cnt_q + 1'b1;
							if (cnt_q == '0) begin
								next_q[free_slot] <= free_slot;
								prev_q[free_slot] <= free_slot;
								head_q            <= free_slot;
							end else begin
								next_q[free_slot] <= node_q;
								prev_q[free_slot] <= bef;
								next_q[bef]       <= free_slot;
								prev_q[node_q]    <= free_slot;
								if (pos_q == '0) head_q <= free_slot;
							end
						end
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					rsp.count    <= cnt_q;
					rsp.is_empty <= (cnt_q == '0);
					done         <= 1'b1;
					busy         <= 1'b0;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/clse_checker.sv =====
module clse_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input clse_pkg::rsp_t rsp
);
	import clse_pkg::*;

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during done");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after request");
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.count == 5'd0))) else $error("empty flag");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.count <= 5'd16)) else $error("count overflow");
endmodule

bind circular_list_sequence_engine_core clse_checker u_clse_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
